### design/mvt_pkg.sv
package mvt_pkg;

    // Element format and the widths that follow from it.
    localparam int ELEM_W    = 32;
    localparam int NUM_ELEMS = 4;
    localparam int PROD_W    = 2 * ELEM_W;
    localparam int PAIR_W    = PROD_W + 1;
    localparam int SUM_W     = PROD_W + 2;
    localparam int DATA_W    = NUM_ELEMS * ELEM_W;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_XFORM = 1'b1
    } cmd_t;

    // Control that the top level sends to every lane.
    typedef struct packed {
        logic       load_we;
        logic [1:0] row_sel;
        logic       en_prod;
        logic       en_pair;
        logic       en_sum;
    } lane_ctrl_t;

endpackage

### design/mvt_lane.sv
module mvt_lane #(
    parameter int LANE = 0,
    parameter int ED   = 4
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  mvt_pkg::lane_ctrl_t                   ctrl,
    input  logic [mvt_pkg::DATA_W-1:0]            vec,
    output logic signed [mvt_pkg::SUM_W-1:0]      sum
);
    import mvt_pkg::*;

    localparam int NP = (ED + 1) / 2;

    logic signed [ELEM_W-1:0] row_reg  [ED];
    logic signed [PROD_W-1:0] prod_reg [ED];
    logic signed [PROD_W-1:0] prod_next[ED];
    logic signed [PAIR_W-1:0] pair_reg [NP];
    logic signed [PAIR_W-1:0] pair_next[NP];
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [SUM_W-1:0]  sum_next;

    // This lane's matrix row; it is written when a load addresses it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < ED; k++)
            begin
                row_reg[k] <= '0;
            end
        end
        else if (ctrl.load_we && (ctrl.row_sel == 2'(LANE)))
        begin
            for (int k = 0; k < ED; k++)
            begin
                row_reg[k] <= $signed(vec[k*ELEM_W +: ELEM_W]);
            end
        end
    end

    // One multiplier per column; the product is registered.
    always_comb
    begin
        for (int k = 0; k < ED; k++)
        begin
            prod_next[k] = PROD_W'(row_reg[k]) * PROD_W'($signed(vec[k*ELEM_W +: ELEM_W]));
        end
    end

    // Products are added in pairs, then the pairs are added.
    for (genvar j = 0; j < NP; j++)
    begin : g_pair
        if (2 * j + 1 < ED)
        begin : g_two
            assign pair_next[j] = PAIR_W'(prod_reg[2*j]) + PAIR_W'(prod_reg[2*j+1]);
        end
        else
        begin : g_one
            assign pair_next[j] = PAIR_W'(prod_reg[2*j]);
        end
    end

    if (NP > 1)
    begin : g_sum2
        assign sum_next = SUM_W'(pair_reg[0]) + SUM_W'(pair_reg[1]);
    end
    else
    begin : g_sum1
        assign sum_next = SUM_W'(pair_reg[0]);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en_prod)
        begin
            for (int k = 0; k < ED; k++)
            begin
                prod_reg[k] <= prod_next[k];
            end
        end
        if (ctrl.en_pair)
        begin
            for (int j = 0; j < NP; j++)
            begin
                pair_reg[j] <= pair_next[j];
            end
        end
        if (ctrl.en_sum)
        begin
            sum_reg <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule

### design/mvt_merge.sv
module mvt_merge #(
    parameter int ED        = 4,
    parameter int FRAC_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  en,
    input  logic signed [mvt_pkg::SUM_W-1:0]      sums [ED],
    output logic [mvt_pkg::DATA_W-1:0]            data,
    output logic                                  overflow
);
    import mvt_pkg::*;

    logic signed [SUM_W-1:0]  shifted [ED];
    logic [ED-1:0]            sat;
    logic [DATA_W-1:0]        data_next;
    logic [DATA_W-1:0]        data_reg;
    logic                     overflow_reg;

    // Drop the fraction bits (floor), then clamp each lane to 32 bits.
    always_comb
    begin
        data_next = '0;
        for (int i = 0; i < ED; i++)
        begin
            shifted[i] = sums[i] >>> FRAC_BITS;
            if (!shifted[i][SUM_W-1] && (|shifted[i][SUM_W-1:ELEM_W-1]))
            begin
                sat[i] = 1'b1;
                data_next[i*ELEM_W +: ELEM_W] = {1'b0, {(ELEM_W-1){1'b1}}};
            end
            else if (shifted[i][SUM_W-1] && !(&shifted[i][SUM_W-1:ELEM_W-1]))
            begin
                sat[i] = 1'b1;
                data_next[i*ELEM_W +: ELEM_W] = {1'b1, {(ELEM_W-1){1'b0}}};
            end
            else
            begin
                sat[i] = 1'b0;
                data_next[i*ELEM_W +: ELEM_W] = shifted[i][ELEM_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg     <= data_next;
            overflow_reg <= |sat;
        end
    end

    assign data     = data_reg;
    assign overflow = overflow_reg;

endmodule

### design/matrix4_vector_transform.sv
// Matrix times vector unit for a 4x4 matrix in signed Q16.16 fixed point.
// Input words arrive on the s_axis channel. tuser bit 0 is the command:
// a load word writes the four elements of tdata into the matrix row named
// by tuser bits 2:1 and produces no output word; a transform word carries
// a column vector and produces one output word with the four dot products.
// Output words leave on the m_axis channel, out0 in the low 32 bits, and
// tuser bit 0 flags that at least one dot product was saturated.
// Each sum is exact, then floored to Q16.16 and clamped to 32 bits.
// One row of multipliers per matrix row works in parallel, so one word is
// accepted every cycle unless a stalled receiver holds back the input, loads
// and transforms mixed freely; a transform sees every load accepted before it.
// The pipeline is four register stages (products, pair sums, row sums,
// output), each with its own valid bit, so a stalled receiver only holds
// back the input once every stage is full; bubbles close up meanwhile.
// Reset clears the matrix to zero and empties the pipeline.
module matrix4_vector_transform #(
    parameter int DIM       = 4,
    parameter int FRAC_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // Fields from bit 0: elem0, elem1, elem2, elem3.
    input  logic [mvt_pkg::DATA_W-1:0]    s_axis_tdata,
    // Fields from bit 0: cmd, row_index.
    input  logic [2:0]                    s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // Fields from bit 0: out0, out1, out2, out3.
    output logic [mvt_pkg::DATA_W-1:0]    m_axis_tdata,
    // Fields from bit 0: overflow.
    output logic [0:0]                    m_axis_tuser
);
    import mvt_pkg::*;

    // Only the first four rows and columns can ever hold nonzero data.
    localparam int ED = (DIM < NUM_ELEMS) ? DIM : NUM_ELEMS;

    logic       prod_v_reg, pair_v_reg, sum_v_reg, out_v_reg;
    logic       rdy_prod, rdy_pair, rdy_sum, rdy_out;
    logic       s_fire;
    cmd_t       cmd;
    lane_ctrl_t ctrl;
    logic signed [SUM_W-1:0] sums [ED];
    logic [DATA_W-1:0]       out_data;
    logic                    out_ovf;

    assign cmd    = cmd_t'(s_axis_tuser[0]);
    assign s_fire = s_axis_tvalid && s_axis_tready;

    // A stage may load when it is empty or its content moves on.
    assign rdy_out  = !out_v_reg  || m_axis_tready;
    assign rdy_sum  = !sum_v_reg  || rdy_out;
    assign rdy_pair = !pair_v_reg || rdy_sum;
    assign rdy_prod = !prod_v_reg || rdy_pair;

    assign s_axis_tready = rdy_prod;

    assign ctrl.load_we = s_fire && (cmd == CMD_LOAD);
    assign ctrl.row_sel = s_axis_tuser[2:1];
    assign ctrl.en_prod = rdy_prod;
    assign ctrl.en_pair = rdy_pair;
    assign ctrl.en_sum  = rdy_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_v_reg <= 1'b0;
            pair_v_reg <= 1'b0;
            sum_v_reg  <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            if (rdy_prod)
            begin
                prod_v_reg <= s_fire && (cmd == CMD_XFORM);
            end
            if (rdy_pair)
            begin
                pair_v_reg <= prod_v_reg;
            end
            if (rdy_sum)
            begin
                sum_v_reg <= pair_v_reg;
            end
            if (rdy_out)
            begin
                out_v_reg <= sum_v_reg;
            end
        end
    end

    for (genvar i = 0; i < ED; i++)
    begin : g_lane
        mvt_lane #(
            .LANE (i),
            .ED   (ED)
        ) u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (ctrl),
            .vec   (s_axis_tdata),
            .sum   (sums[i])
        );
    end

    mvt_merge #(
        .ED        (ED),
        .FRAC_BITS (FRAC_BITS)
    ) u_merge (
        .clk      (clk),
        .en       (rdy_out),
        .sums     (sums),
        .data     (out_data),
        .overflow (out_ovf)
    );

    assign m_axis_tvalid   = out_v_reg;
    assign m_axis_tdata    = out_data;
    assign m_axis_tuser[0] = out_ovf;

    // A load never starts a pipeline entry.
    a_load_no_entry: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire && (cmd == CMD_LOAD) |=> !prod_v_reg)
        else $error("load word entered the pipeline");

    // A transform always starts a pipeline entry.
    a_xform_entry: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire && (cmd == CMD_XFORM) |=> prod_v_reg)
        else $error("transform word was dropped");

    // A new output word comes only from a full row-sum stage.
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_v_reg) |-> $past(sum_v_reg))
        else $error("output word without a source");

    // The overflow flag means at least one lane sits at a limit.
    a_ovf_limit: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |->
            (m_axis_tdata[31:0]   == 32'h7fffffff) || (m_axis_tdata[31:0]   == 32'h80000000) ||
            (m_axis_tdata[63:32]  == 32'h7fffffff) || (m_axis_tdata[63:32]  == 32'h80000000) ||
            (m_axis_tdata[95:64]  == 32'h7fffffff) || (m_axis_tdata[95:64]  == 32'h80000000) ||
            (m_axis_tdata[127:96] == 32'h7fffffff) || (m_axis_tdata[127:96] == 32'h80000000))
        else $error("overflow flag without a saturated lane");

endmodule

### verif/matrix4_vector_transform_checker.sv
`timescale 1ns / 100ps

// Watches both stream channels of the matrix unit. It keeps its own copy of
// the matrix, works out the expected output word for every accepted
// transform word, and compares each output word with the oldest expectation.
module matrix4_vector_transform_checker #(
    parameter int DIM       = 4,
    parameter int FRAC_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    input  logic                          s_axis_tready,
    input  logic [mvt_pkg::DATA_W-1:0]    s_axis_tdata,
    input  logic [2:0]                    s_axis_tuser,
    input  logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    input  logic [mvt_pkg::DATA_W-1:0]    m_axis_tdata,
    input  logic [0:0]                    m_axis_tuser,
    output int                            errors,
    output int                            pending
);

    import mvt_pkg::*;

    typedef struct packed {
        logic                              ovf;
        logic [NUM_ELEMS-1:0][ELEM_W-1:0]  dot;
    } xform_word_t;

    localparam logic signed [SUM_W-1:0] SAT_HI = 66'sd2147483647;
    localparam logic signed [SUM_W-1:0] SAT_LO = -66'sd2147483648;

    logic [ELEM_W-1:0] matrix_copy [DIM*DIM];
    xform_word_t       dot_products_due [$];

    // Exact sum of the four products, floored to the element format and
    // clamped to 32 bits signed.
    function automatic xform_word_t multiply_vector(input logic [DATA_W-1:0] vec);
        xform_word_t             w;
        logic signed [PROD_W-1:0] a;
        logic signed [PROD_W-1:0] e;
        logic signed [PROD_W-1:0] prod;
        logic signed [SUM_W-1:0]  acc;
        w = '0;
        for (int i = 0; i < NUM_ELEMS; i++)
        begin
            if (i < DIM)
            begin
                acc = '0;
                for (int k = 0; k < DIM; k++)
                begin
                    a = {{ELEM_W{matrix_copy[i*DIM+k][ELEM_W-1]}}, matrix_copy[i*DIM+k]};
                    if (k < NUM_ELEMS)
                        e = {{ELEM_W{vec[k*ELEM_W+ELEM_W-1]}}, vec[k*ELEM_W +: ELEM_W]};
                    else
                        e = '0;
                    prod = a * e;
                    acc  = acc + {{2{prod[PROD_W-1]}}, prod};
                end
                acc = acc >>> FRAC_BITS;
                if (acc > SAT_HI)
                begin
                    acc   = SAT_HI;
                    w.ovf = 1'b1;
                end
                else if (acc < SAT_LO)
                begin
                    acc   = SAT_LO;
                    w.ovf = 1'b1;
                end
                w.dot[i] = acc[ELEM_W-1:0];
            end
        end
        return w;
    endfunction

    initial
    begin
        errors  = 0;
        pending = 0;
        for (int n = 0; n < DIM*DIM; n++)
            matrix_copy[n] = '0;
    end

    always @(posedge clk)
    begin
        xform_word_t want;
        xform_word_t got;
        logic [1:0]  row;
        if (!rst_n)
        begin
            for (int n = 0; n < DIM*DIM; n++)
                matrix_copy[n] = '0;
            dot_products_due.delete();
        end
        else
        begin
            // Outputs are checked before the input is applied; a transform
            // cannot come out in the cycle it goes in.
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.ovf = m_axis_tuser[0];
                got.dot = m_axis_tdata;
                if (dot_products_due.size() == 0)
                begin
                    $display("%0t: output word with nothing expected: %h ovf %b",
                             $time, got.dot, got.ovf);
                    errors++;
                end
                else
                begin
                    want = dot_products_due.pop_front();
                    for (int i = 0; i < NUM_ELEMS; i++)
                    begin
                        if (got.dot[i] !== want.dot[i])
                        begin
                            $display("%0t: out%0d expected %h actual %h",
                                     $time, i, want.dot[i], got.dot[i]);
                            errors++;
                        end
                    end
                    if (got.ovf !== want.ovf)
                    begin
                        $display("%0t: overflow expected %b actual %b",
                                 $time, want.ovf, got.ovf);
                        errors++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                row = s_axis_tuser[2:1];
                if (cmd_t'(s_axis_tuser[0]) == CMD_LOAD)
                begin
                    // A row beyond the matrix size is dropped.
                    if (row < DIM)
                        for (int k = 0; k < DIM; k++)
                            matrix_copy[row*DIM+k] =
                                (k < NUM_ELEMS) ? s_axis_tdata[k*ELEM_W +: ELEM_W] : '0;
                end
                else
                    dot_products_due.push_back(multiply_vector(s_axis_tdata));
            end
            pending = dot_products_due.size();
        end
    end

endmodule

### verif/matrix4_vector_transform_tb.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the matrix unit. The checker beside the block
// does all prediction and comparison; this module only drives words,
// throttles both sides and decides when the run is over.
module matrix4_vector_transform_tb;

    import mvt_pkg::*;

    localparam int NUM_RANDOM  = 1800;
    localparam int QUIET_LIMIT = 3000;
    localparam int HOLD_CYCLES = 400;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [DATA_W-1:0]     s_axis_tdata;
    logic [2:0]            s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [DATA_W-1:0]     m_axis_tdata;
    logic [0:0]            m_axis_tuser;

    int   errors;
    int   pending;
    int   quiet_cycles;
    // No idling on either side while calm is set.
    logic calm;
    // Asks the receiver for one long hold-off.
    logic hold_req;

    matrix4_vector_transform i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    matrix4_vector_transform_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .errors        (errors),
        .pending       (pending)
    );

    initial
        clk = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Element values drawn mostly from small and medium magnitudes, so that
    // many dot products stay in range, with full-width values and the
    // corners mixed in to reach saturation and every bit.
    function automatic logic [ELEM_W-1:0] pick_elem();
        logic [ELEM_W-1:0] v;
        case ($urandom_range(9))
            0, 1, 2, 3: v = $urandom_range(32'h0010_0000) - 32'h0008_0000;
            4, 5:       v = $urandom;
            6:
            begin
                case ($urandom_range(4))
                    0:       v = 32'h7FFF_FFFF;
                    1:       v = 32'h8000_0000;
                    2:       v = 32'h0000_0000;
                    3:       v = 32'h0000_0001;
                    default: v = 32'hFFFF_FFFF;
                endcase
            end
            default:    v = $urandom_range(32'h0200_0000) - 32'h0100_0000;
        endcase
        return v;
    endfunction

    function automatic logic [DATA_W-1:0] pick_vector();
        return {pick_elem(), pick_elem(), pick_elem(), pick_elem()};
    endfunction

    // Offers one word and returns at the edge where it is taken. The word is
    // put on the bus right at a clock edge, after any random idle cycles.
    task automatic send_word(input cmd_t op, input logic [1:0] row,
                             input logic [DATA_W-1:0] elems);
        while (!calm && $urandom_range(99) < 21)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= elems;
        s_axis_tuser  <= {row, op};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // Receiver side: random back-pressure, plus one long hold-off on request
    // so that the pipeline fills and the input stalls.
    initial
    begin
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
                m_axis_tready <= calm || ($urandom_range(99) >= 21);
        end
    end

    // Ends the run if neither channel moves a word for too long.
    initial
        quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("matrix4_vector_transform_tb: done, errors");
                $finish;
            end
        end
    end

    initial
    begin
        cmd_t op;
        calm          = 1'b0;
        hold_req      = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. The matrix is still all zero after reset, so the
        // first transform must give zeros even for corner inputs.
        send_word(CMD_XFORM, 2'd3, {32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0});

        // Identity matrix: every vector must come back unchanged.
        send_word(CMD_LOAD, 2'd0, {32'h0, 32'h0, 32'h0, 32'h0001_0000});
        send_word(CMD_LOAD, 2'd1, {32'h0, 32'h0, 32'h0001_0000, 32'h0});
        send_word(CMD_LOAD, 2'd2, {32'h0, 32'h0001_0000, 32'h0, 32'h0});
        send_word(CMD_LOAD, 2'd3, {32'h0001_0000, 32'h0, 32'h0, 32'h0});
        send_word(CMD_XFORM, 2'd0, {32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFD_C000,
                                    32'h0001_8000});
        send_word(CMD_XFORM, 2'd2, {32'hFFFF_FFFF, 32'h0000_0001, 32'h0, 32'hFFFF_FFFF});

        // Corner rows: largest positive, largest negative, tiny values whose
        // products fall below one unit, and mixed signs.
        send_word(CMD_LOAD, 2'd0, {4{32'h7FFF_FFFF}});
        send_word(CMD_LOAD, 2'd1, {4{32'h8000_0000}});
        send_word(CMD_LOAD, 2'd2, {32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001,
                                   32'hFFFF_FFFF});
        send_word(CMD_LOAD, 2'd3, {32'h0, 32'h0000_8000, 32'hFFFF_0000, 32'h0001_0000});
        // Saturation upward in row 0 and downward in row 1, and the reverse.
        send_word(CMD_XFORM, 2'd1, {4{32'h7FFF_FFFF}});
        send_word(CMD_XFORM, 2'd1, {4{32'h8000_0000}});
        // Negative fractions that floor toward minus infinity.
        send_word(CMD_XFORM, 2'd0, {32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF,
                                    32'h0000_0001});
        send_word(CMD_XFORM, 2'd3, {4{32'h0000_8000}});
        send_word(CMD_XFORM, 2'd0, {4{32'hFFFF_8000}});
        // Small sums that stay just in range, and a zero vector.
        send_word(CMD_XFORM, 2'd2, {32'h0, 32'h0, 32'h0, 32'h0000_0002});
        send_word(CMD_XFORM, 2'd1, {4{32'h0}});
        // A load right before a transform must be seen by it.
        send_word(CMD_LOAD, 2'd0, {32'h0, 32'h0, 32'h0, 32'h0002_0000});
        send_word(CMD_XFORM, 2'd0, {32'h0, 32'h0, 32'h0, 32'h0003_0000});

        // Random part. Most of it rewrites the whole matrix and then sends a
        // few columns of a second matrix; the rest is single loads and loose
        // transforms in any order. Every word sent counts toward the total.
        for (int n = 0; n < NUM_RANDOM; )
        begin
            calm = (n >= 600 && n < 800);
            if (n >= 1000 && n < 1010 && !hold_req)
                hold_req = 1'b1;
            if ($urandom_range(99) < 60)
            begin
                for (int r = 0; r < 4; r++)
                    send_word(CMD_LOAD, r[1:0], pick_vector());
                for (int c = $urandom_range(1, 6); c > 0; c--)
                begin
                    send_word(CMD_XFORM, 2'($urandom_range(3)), pick_vector());
                    n++;
                end
                n += 4;
            end
            else
            begin
                op = ($urandom_range(99) < 30) ? CMD_LOAD : CMD_XFORM;
                send_word(op, 2'($urandom_range(3)), pick_vector());
                n++;
            end
        end
        calm = 1'b0;
        s_axis_tvalid <= 1'b0;

        // One more edge so that the checker has queued the last word.
        @(posedge clk);
        wait (pending == 0);
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("matrix4_vector_transform_tb: done, clean");
        else
            $display("matrix4_vector_transform_tb: done, errors");
        $finish;
    end

endmodule
